// File: rtl/indexed_min_heap_core_assert.svh
// Assertion macros for the indexed min-heap core checker.
// Included by the checker file; needs nothing else.
`ifndef INDEXED_MIN_HEAP_CORE_ASSERT_SVH
`define INDEXED_MIN_HEAP_CORE_ASSERT_SVH
// Implication checked every clock outside reset
`define IMH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked every clock outside reset
`define IMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/imh_pkg.sv
// Shared types and codes for the indexed min-heap core.
// No dependencies.
package imh_pkg;
    // Fixed sizes: the internal widths follow from these; the port widths are written out to match
    localparam int HEAP_CAPACITY = 256;
    localparam int ID_SPACE      = 256;
    localparam int COUNT_BITS    = 32;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_ADD    = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_PRESENT   = 3'd4;
endpackage

// File: rtl/indexed_min_heap_core.sv
// Indexed binary min-heap core: slot memory, id-to-slot memory, sift sequencer. Uses imh_pkg.
// Rejected and unused commands go from lookup straight to the root read; push sifts up, pop
// sinks the last entry from the root, and update sifts up or down. The memories have registered
// reads, so each level up passes a read state and a compare state, and each level down a left read,
// a right read and a compare state. One request at a time: the next is accepted at the edge its result is taken.
// Reset: heap size and presence bits clear; slot and id memories do not.
module indexed_min_heap_core
    import imh_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_command,
    input  logic [7:0]                   i_entry_id,
    input  logic signed [31:0]           i_amount,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [7:0]                   o_popped_id,
    output logic signed [31:0]           o_popped_count,
    output logic [7:0]                   o_top_id,
    output logic signed [31:0]           o_top_count,
    output logic                         o_heap_empty,
    output logic [8:0]                   o_entry_total
);
    localparam int SW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
    localparam int IW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
    localparam int FW = $clog2(HEAP_CAPACITY + 1);
    localparam int CW = COUNT_BITS;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOK  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_UPRD  = 4'd3;
    localparam logic [3:0] S_UPCMP = 4'd4;
    localparam logic [3:0] S_DNRD  = 4'd5;
    localparam logic [3:0] S_DNRR  = 4'd6;
    localparam logic [3:0] S_DNCMP = 4'd7;
    localparam logic [3:0] S_TOP   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_POPRD = 4'd10;

    // Memories: slot entries {id, count}, and id -> slot
    logic [IW+CW-1:0] slot_mem [HEAP_CAPACITY];
    logic [SW-1:0]    pos_mem  [ID_SPACE];
    logic [ID_SPACE-1:0] r_present;

    logic [IW+CW-1:0] r_srd;
    logic [SW-1:0]    r_prd;
    logic             s_we, p_we;
    logic [SW-1:0]    s_wa, s_ra, p_wd;
    logic [IW+CW-1:0] s_wd;
    logic [IW-1:0]    p_wa, p_ra;

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            slot_mem[s_wa] <= s_wd;
        end
        r_srd <= slot_mem[s_ra];
    end
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            pos_mem[p_wa] <= p_wd;
        end
        r_prd <= pos_mem[p_ra];
    end

    logic [3:0]       r_state;
    logic [1:0]       r_cmd;
    logic [IW-1:0]    r_id;
    logic signed [CW-1:0] r_amt;
    logic [FW-1:0]    r_fill;
    logic [SW-1:0]    r_pos;      // slot of moving entry
    logic [IW-1:0]    r_mid;      // moving entry id
    logic signed [CW-1:0] r_mcnt; // moving entry count
    logic [IW+CW-1:0] r_left;
    logic [IW-1:0]    r_pid;
    logic signed [CW-1:0] r_pcnt;
    logic             r_ovalid;
    logic [2:0]       r_status;
    logic [IW-1:0]    r_tid;
    logic signed [CW-1:0] r_tcnt;
    logic [IW-1:0]    r_root_id;
    logic signed [CW-1:0] r_root_cnt;

    logic accept;
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);

    // Tree index arithmetic, kept wide enough for the left child of the last slot
    logic [SW:0] up_idx, lc_idx, rc_idx;
    assign up_idx = ({1'b0, r_pos} - (SW+1)'(1)) >> 1;
    assign lc_idx = {r_pos, 1'b1};
    assign rc_idx = {r_pos, 1'b0} + (SW+1)'(2);
    logic lc_ok, rc_ok;
    assign lc_ok = (lc_idx < (SW+1)'(r_fill)) && (r_pos < SW'(HEAP_CAPACITY/2));
    assign rc_ok = (rc_idx < (SW+1)'(r_fill)) && (r_pos < SW'((HEAP_CAPACITY-1)/2));

    logic signed [CW-1:0] rd_cnt, l_cnt;
    logic [IW-1:0] rd_id, l_id;
    assign rd_cnt = r_srd[CW-1:0];
    assign rd_id  = r_srd[IW+CW-1:CW];
    assign l_cnt  = r_left[CW-1:0];
    assign l_id   = r_left[IW+CW-1:CW];

    // Saturating update of the current count: clamp when the carry and sign disagree
    logic signed [CW:0] sum_w;
    logic signed [CW-1:0] sum_sat;
    assign sum_w = {rd_cnt[CW-1], rd_cnt} + {r_amt[CW-1], r_amt};
    always_comb begin
        if (sum_w[CW] != sum_w[CW-1]) begin
            sum_sat = sum_w[CW] ? CMIN : CMAX;
        end else begin
            sum_sat = sum_w[CW-1:0];
        end
    end

    always_comb begin
        s_we = 1'b0; p_we = 1'b0;
        s_wa = r_pos; s_wd = {r_mid, r_mcnt};
        p_wa = r_mid; p_wd = r_pos;
        s_ra = r_pos; p_ra = r_id;
        unique case (r_state)
            S_IDLE:  p_ra = IW'(i_entry_id);
            S_LOOK:  s_ra = r_prd;
            S_UPRD:  s_ra = up_idx[SW-1:0];
            S_DNRD:  s_ra = lc_idx[SW-1:0];
            S_DNRR:  s_ra = rc_idx[SW-1:0];
            S_POPRD: s_ra = SW'(r_fill);
            S_TOP:   s_ra = '0;
            default: s_ra = r_pos;
        endcase
        // Write-back of the moving entry at its final slot, or of the parent or child that swaps into its slot
        if (r_state == S_UPCMP && !(r_pos != '0 && r_mcnt < rd_cnt)) begin
            s_we = 1'b1; p_we = 1'b1;
        end
        if (r_state == S_UPCMP && r_pos != '0 && r_mcnt < rd_cnt) begin
            s_we = 1'b1; s_wd = r_srd; p_we = 1'b1; p_wa = rd_id;
        end
        if (r_state == S_DNCMP) begin
            s_we = 1'b1; p_we = 1'b1;
            if (lc_ok && l_cnt < r_mcnt && !(rc_ok && rd_cnt < l_cnt)) begin
                s_wd = r_left; p_wa = l_id;
            end else if (rc_ok && rd_cnt < r_mcnt && (!lc_ok || rd_cnt < l_cnt)) begin
                s_wd = r_srd; p_wa = rd_id;
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_present <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_command;
                        r_id  <= IW'(i_entry_id);
                        r_amt <= i_amount;
                        r_pid <= '0; r_pcnt <= '0;
                        r_status <= ST_OK;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    unique case (r_cmd)
                        CMD_PUSH: begin
                            if (r_present[r_id]) begin
                                r_status <= ST_PRESENT;
                                r_state <= S_TOP;
                            end else if (r_fill >= FW'(HEAP_CAPACITY)) begin
                                r_status <= ST_FULL;
                                r_state <= S_TOP;
                            end else begin
                                r_present[r_id] <= 1'b1;
                                r_pos <= SW'(r_fill);
                                r_mid <= r_id;
                                r_mcnt <= r_amt;
                                r_fill <= r_fill + FW'(1);
                                r_state <= S_UPRD;
                            end
                        end
                        CMD_POP: begin
                            if (r_fill == '0) begin
                                r_status <= ST_EMPTY;
                                r_state <= S_TOP;
                            end else begin
                                // Capture the cached root and retire its id
                                r_pid <= r_root_id; r_pcnt <= r_root_cnt;
                                r_present[r_root_id] <= 1'b0;
                                r_fill <= r_fill - FW'(1);
                                r_state <= S_POPRD;
                            end
                        end
                        CMD_ADD: begin
                            if (!r_present[r_id]) begin
                                r_status <= ST_NOT_FOUND;
                                r_state <= S_TOP;
                            end else begin
                                r_pos <= r_prd;
                                r_mid <= r_id;
                                r_state <= S_START;
                            end
                        end
                        default: r_state <= S_TOP;
                    endcase
                end
                S_POPRD: begin
                    // Read of the last entry is in flight; it restarts at the root
                    r_state <= S_START;
                    r_pos <= '0;
                end
                S_START: begin
                    if (r_cmd == CMD_POP) begin
                        // r_srd holds the last entry
                        r_mid <= rd_id; r_mcnt <= rd_cnt;
                        r_state <= (r_fill == '0) ? S_TOP : S_DNRD;
                    end else begin
                        r_mcnt <= sum_sat;
                        r_state <= (sum_sat < rd_cnt) ? S_UPRD : S_DNRD;
                    end
                end
                S_UPRD:  r_state <= S_UPCMP;
                S_UPCMP: begin
                    if (r_pos != '0 && r_mcnt < rd_cnt) begin
                        r_pos <= up_idx[SW-1:0];
                        r_state <= S_UPRD;
                    end else r_state <= S_TOP;
                end
                S_DNRD:  r_state <= S_DNRR;
                S_DNRR: begin
                    r_left <= r_srd;
                    r_state <= S_DNCMP;
                end
                S_DNCMP: begin
                    if (lc_ok && l_cnt < r_mcnt && !(rc_ok && rd_cnt < l_cnt)) begin
                        r_pos <= lc_idx[SW-1:0]; r_state <= S_DNRD;
                    end else if (rc_ok && rd_cnt < r_mcnt && (!lc_ok || rd_cnt < l_cnt)) begin
                        r_pos <= rc_idx[SW-1:0]; r_state <= S_DNRD;
                    end else r_state <= S_TOP;
                end
                S_TOP: r_state <= S_DONE;
                S_DONE: begin
                    r_tid <= rd_id; r_tcnt <= rd_cnt;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Cached root, kept current on every root write
    always_ff @(posedge i_clk) begin
        if (s_we && s_wa == '0) begin
            r_root_id  <= s_wd[IW+CW-1:CW];
            r_root_cnt <= s_wd[CW-1:0];
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_popped_id    = 8'(r_pid);
    assign o_popped_count = 32'(r_pcnt);
    assign o_heap_empty   = (r_fill == '0);
    assign o_top_id       = o_heap_empty ? 8'd0 : 8'(r_tid);
    assign o_top_count    = o_heap_empty ? 32'sd0 : 32'(r_tcnt);
    assign o_entry_total  = 9'(r_fill);
endmodule

// File: rtl/imh_checker.sv
// Port-level checker for the indexed min-heap core, with its bind.
// Depends on imh_pkg and indexed_min_heap_core_assert.svh.
`include "indexed_min_heap_core_assert.svh"
module imh_checker
    import imh_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_status,
    input logic       o_heap_empty,
    input logic [8:0] o_entry_total
);
    `IMH_ASSERT_IMPL(a_empty_flag, i_clk, i_rst_n, o_valid, o_heap_empty == (o_entry_total == 9'd0))
    `IMH_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_valid, o_status <= ST_PRESENT)
    `IMH_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `IMH_ASSERT_IMPL(a_pop_empty, i_clk, i_rst_n, o_valid && o_status == ST_EMPTY, o_heap_empty)
endmodule

bind indexed_min_heap_core imh_checker u_imh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_heap_empty(o_heap_empty), .o_entry_total(o_entry_total)
);
